@@ design/lpc_pkg.sv @@
// Shared types, codes and helpers for the LRU program cache.
// No dependencies; imported by every module of the block.
package lpc_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SLOT_W = 4;
    localparam int EVC_W  = 5;

    localparam logic [1:0] ACT_LOOKUP   = 2'd0;
    localparam logic [1:0] ACT_INSERT   = 2'd1;
    localparam logic [1:0] ACT_FLUSH    = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam logic CFG_MAX_PROGRAMS = 1'b0;
    localparam logic CFG_MAX_BYTES    = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_INVALID   = 3'd4,
        ST_TOO_LARGE = 3'd5,
        ST_FLUSHED   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        KIND_BAD,
        KIND_FLUSH,
        KIND_LOOKUP,
        KIND_INSERT
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACT,
        S_MATCH,
        S_EVCHK,
        S_LRU,
        S_EVICT,
        S_ALLOC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        key_ok;
        logic        program_ok;
        logic [31:0] scope_tag;
        logic [47:0] program_key;
        logic [31:0] generation;
        logic [63:0] content_id;
        logic [23:0] program_bytes;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] epoch;
        logic [4:0]  evicted_count;
    } out_t;

    typedef struct packed {
        kind_t       kind;
        logic        program_ok;
        logic [31:0] scope_tag;
        logic [47:0] program_key;
        logic [31:0] generation;
        logic [63:0] content_id;
        logic [23:0] program_bytes;
    } cmd_t;

    // Advance by one, skipping zero on wrap.
    function automatic logic [31:0] bump(input logic [31:0] v);
        logic [31:0] r;
        r = v + 32'd1;
        if (r == 32'd0)
            r = 32'd1;
        return r;
    endfunction

endpackage

@@ design/lpc_front.sv @@
// Front end: classify requests and hold them in a two-entry queue.
// Depends on lpc_pkg.
module lpc_front import lpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  req,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic q_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       cls;
    logic       push;

    // Sort the request into the kind the back end acts upon.
    always_comb
    begin
        cls.program_ok    = req.program_ok;
        cls.scope_tag     = req.scope_tag;
        cls.program_key   = req.program_key;
        cls.generation    = req.generation;
        cls.content_id    = req.content_id;
        cls.program_bytes = req.program_bytes;
        case (req.action)
            ACT_FLUSH:  cls.kind = KIND_FLUSH;
            ACT_LOOKUP: cls.kind = req.key_ok ? KIND_LOOKUP : KIND_BAD;
            ACT_INSERT: cls.kind = req.key_ok ? KIND_INSERT : KIND_BAD;
            default:    cls.kind = KIND_BAD;
        endcase
    end

    assign busy    = (fill_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (fill_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

endmodule

@@ design/lpc_back.sv @@
// Back end: table, scope tracking and the slot-by-slot sequencer.
// Depends on lpc_pkg.
module lpc_back import lpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    input  logic [4:0]  max_programs,
    input  logic [23:0] max_bytes,
    output logic        done,
    output out_t        rsp
);

    state_t state_reg, state_next;

    logic [SLOTS-1:0] valid_reg;
    logic [47:0]      key_mem   [SLOTS];
    logic [63:0]      cont_mem  [SLOTS];
    logic [31:0]      gen_mem   [SLOTS];
    logic [23:0]      bytes_mem [SLOTS];
    logic [31:0]      stamp_mem [SLOTS];
    logic [IDX_W-1:0] free_mem  [SLOTS];

    logic [CNT_W-1:0] free_count_reg, fresh_reg, res_count_reg, evicted_reg;
    logic [23:0]      res_bytes_reg;
    logic [31:0]      clock_reg, epoch_reg, scope_reg, cur_gen_reg;
    logic             scope_on_reg;

    cmd_t             cmd_reg;
    logic [IDX_W-1:0] scan_reg, victim_reg;
    logic [31:0]      victim_stamp_reg;
    logic [23:0]      victim_bytes_reg;
    logic             found_reg;
    status_t          status_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             done_reg;
    out_t             rsp_reg;

    logic             last, hit, need_evict, too_large, new_scope, new_gen;
    logic [IDX_W-1:0] free_top;
    logic [31:0]      clock_bump;

    assign last      = (scan_reg == IDX_W'(SLOTS - 1));
    assign free_top  = free_mem[free_count_reg[IDX_W-1:0] - IDX_W'(1)];
    assign clock_bump = bump(clock_reg);
    assign new_scope = scope_on_reg && (scope_reg != cmd_reg.scope_tag);
    assign new_gen   = scope_on_reg && (cur_gen_reg != cmd_reg.generation);

    always_comb
    begin
        hit = 1'b0;
        if (valid_reg[scan_reg] && key_mem[scan_reg] == cmd_reg.program_key)
        begin
            if (cont_mem[scan_reg] != 64'd0 || cmd_reg.content_id != 64'd0)
                hit = (cont_mem[scan_reg] != 64'd0) &&
                      (cont_mem[scan_reg] == cmd_reg.content_id);
            else
                hit = (gen_mem[scan_reg] == cmd_reg.generation);
        end
    end

    assign too_large = (max_programs == 5'd0) || (max_bytes == 24'd0) ||
                       (cmd_reg.program_bytes > max_bytes);
    assign need_evict = (32'(res_count_reg) >= 32'(max_programs)) ||
                        (32'(res_count_reg) >= 32'(SLOTS)) ||
                        (({1'b0, res_bytes_reg} + {1'b0, cmd_reg.program_bytes})
                         > {1'b0, max_bytes});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (q_valid)
                    state_next = S_ACT;
            S_ACT:
                case (cmd_reg.kind)
                    KIND_LOOKUP: state_next = S_MATCH;
                    KIND_INSERT: state_next = cmd_reg.program_ok ? S_MATCH : S_RESP;
                    default:     state_next = S_RESP;
                endcase
            S_MATCH:
                if (hit)
                    state_next = S_RESP;
                else if (last)
                    state_next = (cmd_reg.kind == KIND_INSERT && !too_large) ?
                                 S_EVCHK : S_RESP;
            S_EVCHK:
                if (!need_evict)
                    state_next = S_ALLOC;
                else if (valid_reg == '0)
                    state_next = S_RESP;
                else
                    state_next = S_LRU;
            S_LRU:
                if (last)
                    state_next = S_EVICT;
            S_EVICT:
                state_next = S_EVCHK;
            S_ALLOC:
                state_next = S_RESP;
            S_RESP:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        q_pop = (state_reg == S_IDLE) && q_valid;
        done  = done_reg;
        rsp   = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Control and table bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            res_count_reg  <= '0;
            res_bytes_reg  <= '0;
            clock_reg      <= '0;
            epoch_reg      <= 32'd1;
            scope_reg      <= '0;
            scope_on_reg   <= 1'b0;
            cur_gen_reg    <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_ACT:
                    case (cmd_reg.kind)
                        KIND_FLUSH:
                        begin
                            valid_reg      <= '0;
                            free_count_reg <= '0;
                            fresh_reg      <= '0;
                            res_count_reg  <= '0;
                            res_bytes_reg  <= '0;
                            epoch_reg      <= bump(epoch_reg);
                            scope_on_reg   <= 1'b0;
                            scope_reg      <= '0;
                            cur_gen_reg    <= '0;
                        end
                        KIND_LOOKUP, KIND_INSERT:
                        begin
                            scope_on_reg <= 1'b1;
                            scope_reg    <= cmd_reg.scope_tag;
                            cur_gen_reg  <= cmd_reg.generation;
                            if (new_scope || (new_gen && cmd_reg.content_id == 64'd0))
                            begin
                                valid_reg      <= '0;
                                free_count_reg <= '0;
                                fresh_reg      <= '0;
                                res_count_reg  <= '0;
                                res_bytes_reg  <= '0;
                                epoch_reg      <= bump(epoch_reg);
                            end
                            else if (new_gen)
                                epoch_reg <= bump(epoch_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                S_MATCH:
                    if (hit)
                        clock_reg <= clock_bump;
                S_EVCHK:
                    found_reg <= 1'b0;
                S_LRU:
                    if (valid_reg[scan_reg] &&
                        (!found_reg || stamp_mem[scan_reg] < victim_stamp_reg))
                        found_reg <= 1'b1;
                S_EVICT:
                begin
                    valid_reg[victim_reg] <= 1'b0;
                    if (32'(free_count_reg) < 32'(SLOTS))
                        free_count_reg <= free_count_reg + CNT_W'(1);
                    if (res_count_reg != '0)
                        res_count_reg <= res_count_reg - CNT_W'(1);
                    res_bytes_reg <= (victim_bytes_reg <= res_bytes_reg) ?
                                     res_bytes_reg - victim_bytes_reg : 24'd0;
                    epoch_reg <= bump(epoch_reg);
                end
                S_ALLOC:
                    if (free_count_reg != '0 || 32'(fresh_reg) < 32'(SLOTS))
                    begin
                        if (free_count_reg != '0)
                        begin
                            free_count_reg     <= free_count_reg - CNT_W'(1);
                            valid_reg[free_top] <= 1'b1;
                        end
                        else
                        begin
                            fresh_reg <= fresh_reg + CNT_W'(1);
                            valid_reg[fresh_reg[IDX_W-1:0]] <= 1'b1;
                        end
                        clock_reg     <= clock_bump;
                        res_count_reg <= res_count_reg + CNT_W'(1);
                        res_bytes_reg <= res_bytes_reg + cmd_reg.program_bytes;
                    end
                S_RESP:
                    done_reg <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    // Payload and table contents.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (q_valid)
                    cmd_reg <= q_cmd;
            S_ACT:
            begin
                scan_reg    <= '0;
                slot_reg    <= '0;
                evicted_reg <= '0;
                case (cmd_reg.kind)
                    KIND_FLUSH:  status_reg <= ST_FLUSHED;
                    KIND_LOOKUP: status_reg <= ST_MISS;
                    KIND_INSERT: status_reg <= cmd_reg.program_ok ? ST_TOO_LARGE :
                                                                     ST_INVALID;
                    default:     status_reg <= ST_INVALID;
                endcase
            end
            S_MATCH:
                if (hit)
                begin
                    stamp_mem[scan_reg] <= clock_bump;
                    slot_reg   <= scan_reg;
                    status_reg <= (cmd_reg.kind == KIND_INSERT) ? ST_PRESENT : ST_HIT;
                end
                else
                    scan_reg <= scan_reg + IDX_W'(1);
            S_EVCHK:
                scan_reg <= '0;
            S_LRU:
            begin
                if (valid_reg[scan_reg] &&
                    (!found_reg || stamp_mem[scan_reg] < victim_stamp_reg))
                begin
                    victim_reg       <= scan_reg;
                    victim_stamp_reg <= stamp_mem[scan_reg];
                    victim_bytes_reg <= bytes_mem[scan_reg];
                end
                scan_reg <= scan_reg + IDX_W'(1);
            end
            S_EVICT:
            begin
                if (32'(free_count_reg) < 32'(SLOTS))
                    free_mem[free_count_reg[IDX_W-1:0]] <= victim_reg;
                evicted_reg <= evicted_reg + CNT_W'(1);
            end
            S_ALLOC:
                if (free_count_reg != '0 || 32'(fresh_reg) < 32'(SLOTS))
                begin
                    if (free_count_reg != '0)
                    begin
                        key_mem[free_top]   <= cmd_reg.program_key;
                        cont_mem[free_top]  <= cmd_reg.content_id;
                        gen_mem[free_top]   <= cmd_reg.generation;
                        bytes_mem[free_top] <= cmd_reg.program_bytes;
                        stamp_mem[free_top] <= clock_bump;
                        slot_reg            <= free_top;
                    end
                    else
                    begin
                        key_mem[fresh_reg[IDX_W-1:0]]   <= cmd_reg.program_key;
                        cont_mem[fresh_reg[IDX_W-1:0]]  <= cmd_reg.content_id;
                        gen_mem[fresh_reg[IDX_W-1:0]]   <= cmd_reg.generation;
                        bytes_mem[fresh_reg[IDX_W-1:0]] <= cmd_reg.program_bytes;
                        stamp_mem[fresh_reg[IDX_W-1:0]] <= clock_bump;
                        slot_reg                        <= fresh_reg[IDX_W-1:0];
                    end
                    status_reg <= ST_INSERTED;
                end
            S_RESP:
            begin
                rsp_reg.status        <= status_reg;
                rsp_reg.slot          <= SLOT_W'(slot_reg);
                rsp_reg.epoch         <= epoch_reg;
                rsp_reg.evicted_count <= EVC_W'(evicted_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ design/lru_program_cache_with_byte_budget_core.sv @@
// Top level of the LRU program cache with a byte budget.
// Depends on lpc_pkg, lpc_front and lpc_back.
//
// Usage:
//   Request channel: req is transferred at a rising edge with start high and
//   busy low. busy rises when the two-entry request queue is full.
//   Result channel: done is high for exactly one cycle with rsp valid; the
//   receiver cannot stall, so take the transfer in that cycle.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 max_programs, 1 max_bytes). Write only while the block is idle.
// Sequencing (back end scans one slot per cycle):
//   invalid or flush: no scan; the command goes straight to the response.
//   lookup: a match scan over the slots; a hit stops the scan early.
//   insert: match scan, an LRU scan and an evict step per eviction, then
//   allocation. The front accepts while the back works, until it is full.
// Reset: asynchronous, clears the valid bits, counters, scope and the
//   queue; epoch restarts at 1 and the limits return to 16 and 1 MiB.
//   No clearing pass is needed.
module lru_program_cache_with_byte_budget_core import lpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         req,
    output logic        done,
    output out_t        rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    logic [4:0]  max_programs_reg;
    logic [23:0] max_bytes_reg;
    logic        q_valid, q_pop;
    cmd_t        q_cmd;

    // Hold the limits; write whichever register the index names.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_programs_reg <= 5'd16;
            max_bytes_reg    <= 24'd1048576;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_PROGRAMS: max_programs_reg <= cfg_data[4:0];
                CFG_MAX_BYTES:    max_bytes_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lpc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    lpc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .max_programs (max_programs_reg),
        .max_bytes    (max_bytes_reg),
        .done         (done),
        .rsp          (rsp)
    );

endmodule
